/* rtl/core/rc4_pkg.sv */
// Shared types and constants for the RC4 cipher engine.
// Used by every module in rtl/core but the checker; depends on nothing else.
package rc4_pkg;

	localparam int SBOX_SIZE     = 256;
	localparam int KEY_MAX_BYTES = 256;

	// Key count saturates at the key limit; nine bits hold the limit itself.
	localparam logic [8:0] KEY_LIMIT = 9'(KEY_MAX_BYTES);
	localparam logic [7:0] SBOX_LAST = 8'(SBOX_SIZE - 1);

	localparam logic CMD_KEY  = 1'b0;
	localparam logic CMD_DATA = 1'b1;

	typedef logic [7:0] byte_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_D_RD_I,
		ST_D_RD_J,
		ST_D_WR_I,
		ST_D_WR_J,
		ST_D_OUT,
		ST_K_STORE,
		ST_K_RD,
		ST_K_ACC,
		ST_K_WR1,
		ST_K_WR2
	} state_t;

	// Port of the permutation memory.
	typedef struct packed {
		logic  we;
		byte_t waddr;
		byte_t wdata;
		byte_t raddr;
		logic  clear;
	} sbox_req_t;

	// Port of the key byte memory.
	typedef struct packed {
		logic  we;
		byte_t waddr;
		byte_t wdata;
		byte_t raddr;
	} key_req_t;

	// Pending request handed from the top level to the sequencer.
	typedef struct packed {
		logic  pend;
		logic  command;
		byte_t value;
		logic  last;
	} req_t;

	// Status from the sequencer back to the top level.
	typedef struct packed {
		logic  busy;
		logic  take;
		logic  res_valid;
		byte_t ks;
	} ctrl_stat_t;

endpackage

/* rtl/core/rc4_stream_cipher.sv */
// RC4 cipher engine top level. A data request runs through the sequencer's read, write and
// output states and gives its result once the output register can load; the next request
// is taken only after that. A key byte without last is stored and frees the input; the last
// key byte frees it only after the schedule has swapped all 256 entries (read, sum, two writes).
// Reset clears the control state and restores the identity permutation at once.
module rc4_stream_cipher import rc4_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  valid,
	output logic  stall,
	input  logic  command,
	input  byte_t value,
	input  logic  last,
	output logic  out_valid,
	input  logic  out_stall,
	output byte_t data_out,
	output logic  last_out
);

	logic       pend_q;
	logic       command_q;
	byte_t      value_q;
	logic       last_q;
	logic       out_valid_q;
	byte_t      data_out_q;
	logic       last_out_q;

	logic       accept;
	logic       res_ready;
	req_t       req;
	ctrl_stat_t stat;
	sbox_req_t  sb_req;
	key_req_t   key_req;
	byte_t      sb_rdata;
	byte_t      key_rdata;

	// One request at a time: the input stays stalled from acceptance until the
	// sequencer is back in idle.
	assign accept = valid && !stall;
	assign stall  = pend_q || stat.busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= 1'b0;
		end else if (accept) begin
			pend_q <= 1'b1;
		end else if (stat.take) begin
			pend_q <= 1'b0;
		end
	end

	// The request payload stays put until the next acceptance, which cannot
	// happen before the sequencer has finished with it.
	always_ff @(posedge clk) begin
		if (accept) begin
			command_q <= command;
			value_q   <= value;
			last_q    <= last;
		end
	end

	assign req.pend    = pend_q;
	assign req.command = command_q;
	assign req.value   = value_q;
	assign req.last    = last_q;

	// The output register may load when empty or when its content leaves now.
	assign res_ready = !out_valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (stat.res_valid) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (stat.res_valid) begin
			data_out_q <= value_q ^ stat.ks;
			last_out_q <= last_q;
		end
	end

	assign out_valid = out_valid_q;
	assign data_out  = data_out_q;
	assign last_out  = last_out_q;

	rc4_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.res_ready (res_ready),
		.sb_rdata  (sb_rdata),
		.key_rdata (key_rdata),
		.sb_req    (sb_req),
		.key_req   (key_req),
		.stat      (stat)
	);

	rc4_sbox u_sbox (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (sb_req),
		.rdata  (sb_rdata)
	);

	rc4_key_mem u_key_mem (
		.clk   (clk),
		.req   (key_req),
		.rdata (key_rdata)
	);

endmodule

/* rtl/core/rc4_add.sv */
// Shared three-operand 8-bit adder for the keystream's i, j and t and the schedule's j sum.
// Depends on rc4_pkg.
module rc4_add import rc4_pkg::*; (
	input  byte_t a,
	input  byte_t b,
	input  byte_t c,
	output byte_t sum
);

	// All sums are modulo 256.
	assign sum = a + b + c;

endmodule

/* rtl/core/rc4_sbox.sv */
// Permutation memory: 256 bytes, one write and one registered read per cycle.
// Per-entry valid bits make an unwritten entry read as its own index.
// Depends on rc4_pkg.
module rc4_sbox import rc4_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  sbox_req_t req,
	output byte_t     rdata
);

	byte_t                mem [SBOX_SIZE];
	logic [SBOX_SIZE-1:0] valid_q;
	byte_t                rdata_q;
	byte_t                raddr_q;
	logic                 rvalid_q;

	always_ff @(posedge clk) begin
		if (req.we) begin
			mem[req.waddr] <= req.wdata;
		end
		rdata_q  <= mem[req.raddr];
		rvalid_q <= valid_q[req.raddr];
		raddr_q  <= req.raddr;
	end

	// Clearing the valid bits restores the identity permutation.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (req.clear) begin
			valid_q <= '0;
		end else if (req.we) begin
			valid_q[req.waddr] <= 1'b1;
		end
	end

	assign rdata = rvalid_q ? rdata_q : raddr_q;

endmodule

/* rtl/core/rc4_key_mem.sv */
// Key byte memory: 256 bytes, one write and one registered read per cycle.
// Depends on rc4_pkg.
module rc4_key_mem import rc4_pkg::*; (
	input  logic     clk,
	input  key_req_t req,
	output byte_t    rdata
);

	byte_t mem [SBOX_SIZE];
	byte_t rdata_q;

	always_ff @(posedge clk) begin
		if (req.we) begin
			mem[req.waddr] <= req.wdata;
		end
		rdata_q <= mem[req.raddr];
	end

	assign rdata = rdata_q;

endmodule

/* rtl/core/rc4_ctrl.sv */
// Sequencer of the RC4 engine: key storing, key schedule and keystream steps,
// which between them drive one shared adder and the two memories.
// Depends on rc4_pkg and rc4_add.
module rc4_ctrl import rc4_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  req_t       req,
	input  logic       res_ready,
	input  byte_t      sb_rdata,
	input  byte_t      key_rdata,
	output sbox_req_t  sb_req,
	output key_req_t   key_req,
	output ctrl_stat_t stat
);

	state_t     state_q, state_d;
	byte_t      i_q, j_q;
	logic [8:0] key_count_q;
	logic [8:0] len_q;
	byte_t      acc_q, n_q, kidx_q;
	byte_t      si_q, t_q;
	logic       byp_q;

	byte_t      add_a, add_b, add_c, add_sum;
	logic       key_room;
	logic [8:0] len_new;
	logic       kidx_wrap;

	rc4_add u_add (
		.a   (add_a),
		.b   (add_b),
		.c   (add_c),
		.sum (add_sum)
	);

	assign key_room  = key_count_q < KEY_LIMIT;
	assign len_new   = key_room ? key_count_q + 9'd1 : key_count_q;
	assign kidx_wrap = ({1'b0, kidx_q} + 9'd1) == len_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d        = state_q;
		sb_req         = '0;
		key_req        = '0;
		add_a          = '0;
		add_b          = '0;
		add_c          = '0;
		stat.busy      = state_q != ST_IDLE;
		stat.take      = 1'b0;
		stat.res_valid = 1'b0;
		// A keystream index equal to j was read while j was being written.
		stat.ks        = byp_q ? si_q : sb_rdata;
		unique case (state_q)
			ST_IDLE: begin
				if (req.pend) begin
					stat.take = 1'b1;
					state_d   = (req.command == CMD_DATA) ? ST_D_RD_I : ST_K_STORE;
				end
			end
			ST_D_RD_I: begin
				add_a         = i_q;
				add_b         = 8'd1;
				sb_req.raddr  = add_sum;
				state_d       = ST_D_RD_J;
			end
			ST_D_RD_J: begin
				add_a         = j_q;
				add_b         = sb_rdata;
				sb_req.raddr  = add_sum;
				state_d       = ST_D_WR_I;
			end
			ST_D_WR_I: begin
				sb_req.we     = 1'b1;
				sb_req.waddr  = i_q;
				sb_req.wdata  = sb_rdata;
				add_a         = si_q;
				add_b         = sb_rdata;
				state_d       = ST_D_WR_J;
			end
			ST_D_WR_J: begin
				sb_req.we     = 1'b1;
				sb_req.waddr  = j_q;
				sb_req.wdata  = si_q;
				sb_req.raddr  = t_q;
				state_d       = ST_D_OUT;
			end
			ST_D_OUT: begin
				sb_req.raddr  = t_q;
				if (res_ready) begin
					stat.res_valid = 1'b1;
					state_d        = ST_IDLE;
				end
			end
			ST_K_STORE: begin
				key_req.we    = key_room;
				key_req.waddr = key_count_q[7:0];
				key_req.wdata = req.value;
				if (req.last) begin
					sb_req.clear = 1'b1;
					state_d      = ST_K_RD;
				end else begin
					state_d      = ST_IDLE;
				end
			end
			ST_K_RD: begin
				sb_req.raddr  = n_q;
				key_req.raddr = kidx_q;
				state_d       = ST_K_ACC;
			end
			ST_K_ACC: begin
				add_a         = acc_q;
				add_b         = sb_rdata;
				add_c         = key_rdata;
				sb_req.raddr  = add_sum;
				state_d       = ST_K_WR1;
			end
			ST_K_WR1: begin
				sb_req.we     = 1'b1;
				sb_req.waddr  = n_q;
				sb_req.wdata  = sb_rdata;
				state_d       = ST_K_WR2;
			end
			ST_K_WR2: begin
				sb_req.we     = 1'b1;
				sb_req.waddr  = acc_q;
				sb_req.wdata  = si_q;
				state_d       = (n_q == SBOX_LAST) ? ST_IDLE : ST_K_RD;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Architectural indices and key count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			i_q         <= '0;
			j_q         <= '0;
			key_count_q <= '0;
		end else begin
			case (state_q)
				ST_D_RD_I:  i_q <= add_sum;
				ST_D_RD_J:  j_q <= add_sum;
				ST_K_STORE: key_count_q <= req.last ? 9'd0 : len_new;
				ST_K_WR2: begin
					if (n_q == SBOX_LAST) begin
						i_q <= '0;
						j_q <= '0;
					end
				end
				default: ;
			endcase
		end
	end

	// Working registers of the current step.
	always_ff @(posedge clk) begin
		case (state_q)
			ST_D_RD_J: si_q  <= sb_rdata;
			ST_D_WR_I: t_q   <= add_sum;
			ST_D_WR_J: byp_q <= t_q == j_q;
			ST_K_STORE: begin
				len_q  <= len_new;
				n_q    <= '0;
				kidx_q <= '0;
				acc_q  <= '0;
			end
			ST_K_ACC: begin
				acc_q <= add_sum;
				si_q  <= sb_rdata;
			end
			ST_K_WR2: begin
				n_q    <= n_q + 8'd1;
				kidx_q <= kidx_wrap ? 8'd0 : kidx_q + 8'd1;
			end
			default: ;
		endcase
	end

endmodule

/* rtl/core/rc4_checker.sv */
// Port-level checks for the RC4 cipher engine, bound to its top level.
// Depends only on the top level's ports.
module rc4_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       valid,
	input logic       stall,
	input logic       out_valid,
	input logic       out_stall,
	input logic [7:0] data_out,
	input logic       last_out
);

	// A stalled result holds.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(data_out) && $stable(last_out))
		else $error("stalled result changed");

	// Only one request is in work at a time.
	a_one_req: assert property (@(posedge clk) disable iff (!arst_n)
		valid && !stall |=> stall)
		else $error("input not stalled after acceptance");

	// A result appears only while a request is in work.
	a_res_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(stall))
		else $error("result without a request in work");

	// No result follows an acceptance in the very next cycle.
	a_res_latency: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> !$past(valid && !stall))
		else $error("result too early after acceptance");

endmodule

bind rc4_stream_cipher rc4_checker u_rc4_checker (.*);
